[rtl/core/amb_pkg.sv]
// Shared types and constants for the ambisonic panner encoder.
// No dependencies; used by the encoder and sequencer modules in rtl/core.
`default_nettype none
package amb_pkg;

	localparam logic [16:0] PA = 17'd102944;
	localparam logic [16:0] PB = 17'd42048;
	localparam logic [16:0] PC = 17'd4640;
	localparam logic signed [17:0] W_GAIN = 18'sd23167;

	localparam logic [2:0] CH_W = 3'd0;
	localparam logic [2:0] CH_X = 3'd1;
	localparam logic [2:0] CH_Y = 3'd2;
	localparam logic [2:0] CH_Z = 3'd3;
	localparam logic [2:0] CH_U = 3'd4;
	localparam logic [2:0] CH_V = 3'd5;
	localparam logic [2:0] CH_P = 3'd6;
	localparam logic [2:0] CH_Q = 3'd7;

	localparam logic [1:0] REG_ORDER = 2'd0;
	localparam logic [1:0] REG_AZ    = 2'd1;
	localparam logic [1:0] REG_EL    = 2'd2;

	// per-item setup handed from the front end to the sequencer
	typedef struct packed {
		logic [1:0]  ord;
		logic        use_el;
		logic        zpoly;
		logic [31:0] azp;
		logic [31:0] elp;
	} setup_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_stat_t;

endpackage
`default_nettype wire

[rtl/core/ambisonic_panner_encoder.sv]
// Ambisonic panner encoder, orders 1 to 3, one mono sample per transfer.
// Every sine/cosine and every Q15 gain step of a sample runs through one shared
// multiplier under a job sequencer, and the work per sample grows with the order
// and with whether the elevation factor applies. The input stalls while a sample
// is in work; the finished result moves to an output register, so the next
// sample can start while it waits there. A sample that finishes while that
// register still holds an unaccepted result waits too, and the input stays
// stalled until it moves. Configuration (index 0 order, 1 azimuth, 2 elevation)
// is always ready.
`default_nettype none
module ambisonic_panner_encoder #(
	parameter int SAMPLE_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]  audio_sample,
	input  wire logic [ANGLE_BITS-1:0]          azimuth_turn,
	input  wire logic [ANGLE_BITS-1:0]          elevation_frac,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [SAMPLE_BITS-1:0]       w_channel,
	output logic signed [SAMPLE_BITS-1:0]       x_channel,
	output logic signed [SAMPLE_BITS-1:0]       y_channel,
	output logic signed [SAMPLE_BITS-1:0]       z_channel,
	output logic signed [SAMPLE_BITS-1:0]       u_channel,
	output logic signed [SAMPLE_BITS-1:0]       v_channel,
	output logic signed [SAMPLE_BITS-1:0]       p_channel,
	output logic signed [SAMPLE_BITS-1:0]       q_channel,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [ANGLE_BITS-1:0]          cfg_data
);
	logic [1:0]            order_q;
	logic [ANGLE_BITS-1:0] faz_q, fel_q, prev_az_q, prev_el_q;
	logic                  out_valid_q;
	logic [7:0][SAMPLE_BITS-1:0] out_q;
	logic [7:0][SAMPLE_BITS-1:0] res;

	logic                  accept, changed, take;
	logic [ANGLE_BITS-1:0] az_sel, el_sel;
	amb_pkg::setup_t       setup;
	amb_pkg::seq_stat_t    stat;

	assign accept = in_valid && !in_stall;
	assign changed = (azimuth_turn != prev_az_q) || (elevation_frac != prev_el_q);
	assign az_sel = changed ? azimuth_turn : faz_q;
	assign el_sel = changed ? elevation_frac : fel_q;

	always_comb begin
		setup.ord = (order_q == 2'd0) ? 2'd1 : order_q;
		setup.use_el = changed ? (elevation_frac != prev_el_q) : (fel_q != '0);
		setup.zpoly = changed || (fel_q != '0);
		setup.azp = {az_sel, {(32-ANGLE_BITS){1'b0}}};
		setup.elp = {1'b0, el_sel, {(31-ANGLE_BITS){1'b0}}} - 32'h4000_0000;
	end

	amb_seq #(.SAMPLE_BITS(SAMPLE_BITS)) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.setup(setup),
		.sample(audio_sample),
		.take(take),
		.stat(stat),
		.res(res)
	);

	assign in_stall = stat.busy;
	assign take = stat.done && (!out_valid_q || !out_stall);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 2'd1;
			faz_q <= '0;
			fel_q <= '0;
			prev_az_q <= '0;
			prev_el_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					amb_pkg::REG_ORDER: order_q <= cfg_data[1:0];
					amb_pkg::REG_AZ:    faz_q <= cfg_data;
					amb_pkg::REG_EL:    fel_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept) begin
				prev_az_q <= azimuth_turn;
				prev_el_q <= elevation_frac;
			end
			if (take) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_q <= res;
	end

	assign out_valid = out_valid_q;
	assign w_channel = out_q[amb_pkg::CH_W];
	assign x_channel = out_q[amb_pkg::CH_X];
	assign y_channel = out_q[amb_pkg::CH_Y];
	assign z_channel = out_q[amb_pkg::CH_Z];
	assign u_channel = out_q[amb_pkg::CH_U];
	assign v_channel = out_q[amb_pkg::CH_V];
	assign p_channel = out_q[amb_pkg::CH_P];
	assign q_channel = out_q[amb_pkg::CH_Q];

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> stat.busy) else $error("sequencer idle after input transfer");
	a_out_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(take)) else $error("output valid without result");
	a_take_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.done && !out_valid_q) |=> out_valid_q) else $error("result not moved out");
`endif

endmodule
`default_nettype wire

[rtl/core/amb_mul.sv]
// Shared signed multiplier used by the sequencer for polynomial and gain steps.
// Depends on nothing.
`default_nettype none
module amb_mul #(
	parameter int MA = 18
) (
	input  wire logic signed [MA-1:0]    a,
	input  wire logic signed [17:0]      b,
	output logic signed      [MA+17:0]   p
);
	assign p = MA'(a) * b;
endmodule
`default_nettype wire

[rtl/core/amb_seq.sv]
// Sequencer: sine polynomial and Q15 gain chain over one shared multiplier.
// Depends on amb_pkg and amb_mul.
`default_nettype none
module amb_seq #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire amb_pkg::setup_t                setup,
	input  wire logic signed [SAMPLE_BITS-1:0]  sample,
	input  wire logic                           take,
	output amb_pkg::seq_stat_t                  stat,
	output logic [7:0][SAMPLE_BITS-1:0]         res
);
	localparam int MA = (SAMPLE_BITS + 2 > 18) ? SAMPLE_BITS + 2 : 18;
	localparam int PW = MA + 18;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LAUNCH = 3'd1;
	localparam logic [2:0] S_POLY = 3'd2;
	localparam logic [2:0] S_SCALE = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	localparam logic [3:0] J_W = 4'd0;
	localparam logic [3:0] J_Z = 4'd1;
	localparam logic [3:0] J_CE = 4'd2;
	localparam logic [3:0] J_H1C = 4'd3;
	localparam logic [3:0] J_H1S = 4'd4;
	localparam logic [3:0] J_H2C = 4'd5;
	localparam logic [3:0] J_H2S = 4'd6;
	localparam logic [3:0] J_H3C = 4'd7;
	localparam logic [3:0] J_H3S = 4'd8;
	localparam logic [3:0] J_END = 4'd9;

	localparam logic signed [MA-1:0] SMAX_V = {{(MA-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [MA-1:0] SMIN_V = ~SMAX_V;

	logic [2:0]               state_q;
	logic [3:0]               job_q;
	logic [1:0]               pstep_q;
	logic [1:0]               nmul_q;
	logic                     first_q;
	logic signed [SAMPLE_BITS-1:0] s_q;
	amb_pkg::setup_t          set_q;
	logic [16:0]              u_q, u2_q, t_q;
	logic                     neg_q;
	logic signed [17:0]       trig_q, ce_q;
	logic signed [MA-1:0]     v_q;
	logic [7:0][SAMPLE_BITS-1:0] res_q;

	logic signed [MA-1:0]     mul_a;
	logic signed [17:0]       mul_b;
	logic signed [PW-1:0]     prod;
	logic signed [PW-1:0]     prod_r;
	logic signed [MA-1:0]     v_new;
	logic [16:0]              prod16;
	logic [16:0]              r_pos;
	logic signed [17:0]       r_sgn;
	logic [31:0]              azp2, ph;
	logic [1:0]               kmul;
	logic [2:0]               slot;
	logic [3:0]               job_nxt;
	logic [SAMPLE_BITS-1:0]   v_sat;
	logic [16:0]              u_new;

	amb_mul #(.MA(MA)) u_mul (.a(mul_a), .b(mul_b), .p(prod));

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_POLY) begin
			case (pstep_q)
				2'd0: begin mul_a = MA'({1'b0, u_q});  mul_b = {1'b0, u_q}; end
				2'd1: begin mul_a = MA'({1'b0, u2_q}); mul_b = {1'b0, amb_pkg::PC}; end
				2'd2: begin mul_a = MA'({1'b0, t_q});  mul_b = {1'b0, u2_q}; end
				default: begin mul_a = MA'({1'b0, t_q}); mul_b = {1'b0, u_q}; end
			endcase
		end else begin
			mul_a = first_q ? MA'(s_q) : v_q;
			mul_b = first_q ? trig_q : ce_q;
		end
	end

	assign prod16 = prod[32:16];
	assign r_pos = 17'((18'(prod16) + 18'd1) >> 1);
	assign r_sgn = neg_q ? -$signed({1'b0, r_pos}) : $signed({1'b0, r_pos});
	assign prod_r = prod + PW'(16384);
	assign v_new = MA'(prod_r >>> 15);

	always_comb begin
		if (v_new > SMAX_V) v_sat = SAMPLE_BITS'(SMAX_V);
		else if (v_new < SMIN_V) v_sat = SAMPLE_BITS'(SMIN_V);
		else v_sat = SAMPLE_BITS'(v_new);
	end

	always_comb begin
		kmul = 2'd1;
		slot = amb_pkg::CH_W;
		job_nxt = J_END;
		unique case (job_q)
			J_W:   begin slot = amb_pkg::CH_W; job_nxt = J_Z; end
			J_Z:   begin slot = amb_pkg::CH_Z; job_nxt = J_CE; end
			J_CE:  begin job_nxt = J_H1C; end
			J_H1C: begin slot = amb_pkg::CH_X; job_nxt = J_H1S; end
			J_H1S: begin
				slot = amb_pkg::CH_Y;
				job_nxt = (set_q.ord == 2'd1) ? J_END : J_H2C;
			end
			J_H2C: begin kmul = 2'd2; slot = amb_pkg::CH_U; job_nxt = J_H2S; end
			J_H2S: begin
				kmul = 2'd2;
				slot = amb_pkg::CH_V;
				job_nxt = (set_q.ord == 2'd3) ? J_H3C : J_END;
			end
			J_H3C: begin kmul = 2'd3; slot = amb_pkg::CH_P; job_nxt = J_H3S; end
			J_H3S: begin kmul = 2'd3; slot = amb_pkg::CH_Q; job_nxt = J_END; end
			default: begin job_nxt = J_END; end
		endcase
	end

	always_comb begin
		azp2 = set_q.azp << 1;
		ph = set_q.elp;
		case (job_q)
			J_Z:           ph = set_q.elp;
			J_CE:          ph = set_q.elp + 32'h4000_0000;
			J_H1C:         ph = set_q.azp + 32'h4000_0000;
			J_H1S:         ph = set_q.azp;
			J_H2C:         ph = azp2 + 32'h4000_0000;
			J_H2S:         ph = azp2;
			J_H3C:         ph = azp2 + set_q.azp + 32'h4000_0000;
			J_H3S:         ph = azp2 + set_q.azp;
			default:       ph = set_q.elp;
		endcase
		u_new = ph[30] ? 17'(17'h10000 - {1'b0, ph[29:14]}) : {1'b0, ph[29:14]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q <= J_W;
			pstep_q <= '0;
			nmul_q <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_LAUNCH;
						job_q <= J_W;
					end
				end
				S_LAUNCH: begin
					if (job_q == J_END) begin
						state_q <= S_DONE;
					end else if (job_q == J_W) begin
						first_q <= 1'b1;
						nmul_q <= '0;
						state_q <= S_SCALE;
					end else if (job_q == J_Z && (set_q.ord != 2'd1 || !set_q.zpoly)) begin
						job_q <= job_nxt;
					end else if (job_q == J_CE && !set_q.use_el) begin
						job_q <= job_nxt;
					end else begin
						pstep_q <= '0;
						state_q <= S_POLY;
					end
				end
				S_POLY: begin
					pstep_q <= pstep_q + 2'd1;
					if (pstep_q == 2'd3) begin
						if (job_q == J_CE) begin
							job_q <= job_nxt;
							state_q <= S_LAUNCH;
						end else begin
							first_q <= 1'b1;
							nmul_q <= (job_q != J_Z && set_q.use_el) ? kmul : 2'd0;
							state_q <= S_SCALE;
						end
					end
				end
				S_SCALE: begin
					first_q <= 1'b0;
					if (!first_q) nmul_q <= nmul_q - 2'd1;
					if ((first_q && nmul_q == 2'd0) || (!first_q && nmul_q == 2'd1)) begin
						job_q <= job_nxt;
						state_q <= S_LAUNCH;
					end
				end
				S_DONE: begin
					if (take) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			s_q <= sample;
			set_q <= setup;
			res_q <= '0;
			trig_q <= amb_pkg::W_GAIN;
		end
		if (state_q == S_LAUNCH) begin
			if (job_q == J_Z && set_q.ord == 2'd1 && !set_q.zpoly) begin
				res_q[amb_pkg::CH_Z] <= s_q;
			end
			if (job_q == J_W) trig_q <= amb_pkg::W_GAIN;
			u_q <= u_new;
			neg_q <= ph[31];
		end
		if (state_q == S_POLY) begin
			case (pstep_q)
				2'd0: u2_q <= prod16;
				2'd1: t_q <= amb_pkg::PB - prod16;
				2'd2: t_q <= amb_pkg::PA - prod16;
				default: begin
					if (job_q == J_CE) ce_q <= r_sgn;
					else trig_q <= r_sgn;
				end
			endcase
		end
		if (state_q == S_SCALE) begin
			v_q <= v_new;
			if ((first_q && nmul_q == 2'd0) || (!first_q && nmul_q == 2'd1)) begin
				res_q[slot] <= v_sat;
			end
		end
	end

	assign stat.busy = (state_q != S_IDLE);
	assign stat.done = (state_q == S_DONE);
	assign res = res_q;

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for ambisonic_panner_encoder.
// Holds a bit-accurate fixed-point encoder predictor and random flow control on both sides.
// Depends on rtl/core/amb_pkg.sv and rtl/core/ambisonic_panner_encoder.sv.
`default_nettype none
module tb_top;

	typedef logic [7:0][15:0] chans_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] audio_sample = '0;
	logic [15:0] azimuth_turn = '0;
	logic [15:0] elevation_frac = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] w_channel, x_channel, y_channel, z_channel;
	logic signed [15:0] u_channel, v_channel, p_channel, q_channel;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = amb_pkg::REG_ORDER;
	logic [15:0] cfg_data = '0;

	ambisonic_panner_encoder u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.audio_sample(audio_sample), .azimuth_turn(azimuth_turn),
		.elevation_frac(elevation_frac),
		.out_valid(out_valid), .out_stall(out_stall),
		.w_channel(w_channel), .x_channel(x_channel), .y_channel(y_channel),
		.z_channel(z_channel), .u_channel(u_channel), .v_channel(v_channel),
		.p_channel(p_channel), .q_channel(q_channel),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// encoder state mirror
	logic [1:0] m_order = 2'd1;
	logic [15:0] m_fix_az = '0;
	logic [15:0] m_fix_el = '0;
	logic [15:0] m_prev_az = '0;
	logic [15:0] m_prev_el = '0;

	chans_t encoded_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_results = 0;
	int burst_left = 0;
	int stall_mode = 0;
	string ch_name[8] = '{"W", "X", "Y", "Z", "U", "V", "P", "Q"};

	function automatic longint quad_poly(longint unsigned u);
		longint unsigned u2, t;
		u2 = (u * u) >> 16;
		t = (64'(amb_pkg::PC) * u2) >> 16;
		t = 64'(amb_pkg::PB) - t;
		t = (t * u2) >> 16;
		t = 64'(amb_pkg::PA) - t;
		t = (t * u) >> 16;
		return longint'((t + 1) >> 1);
	endfunction

	function automatic longint sin_q15(logic [31:0] ph);
		longint unsigned x, u;
		longint p;
		x = 64'(ph[29:14]);
		u = ph[30] ? (65536 - x) : x;
		p = quad_poly(u);
		return ph[31] ? -p : p;
	endfunction

	function automatic longint cos_q15(logic [31:0] ph);
		return sin_q15(ph + 32'h4000_0000);
	endfunction

	function automatic longint mul_q15(longint v, longint c);
		return (v * c + 16384) >>> 15;
	endfunction

	function automatic logic [15:0] clip16(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic logic [15:0] harmonic(longint s, longint trig, longint ce, int k,
			bit use_el);
		longint v;
		v = mul_q15(s, trig);
		if (use_el)
			for (int i = 0; i < k; i++) v = mul_q15(v, ce);
		return clip16(v);
	endfunction

	function automatic chans_t encode(logic signed [15:0] smp, logic [15:0] az,
			logic [15:0] el);
		chans_t r;
		longint s, z, ce;
		logic [31:0] azp, elp, ph;
		bit use_el;
		int ord, slot;
		s = longint'(smp);
		ord = (m_order == 2'd0) ? 1 : int'(m_order);
		if (az != m_prev_az || el != m_prev_el) begin
			azp = {az, 16'h0};
			elp = {1'b0, el, 15'h0} - 32'h4000_0000;
			use_el = (el != m_prev_el);
			z = mul_q15(s, sin_q15(elp));
		end else begin
			azp = {m_fix_az, 16'h0};
			elp = {1'b0, m_fix_el, 15'h0} - 32'h4000_0000;
			use_el = (m_fix_el != 0);
			z = use_el ? mul_q15(s, sin_q15(elp)) : s;
		end
		ce = cos_q15(elp);
		r = '0;
		r[amb_pkg::CH_W] = clip16(mul_q15(s, longint'(amb_pkg::W_GAIN)));
		if (ord == 1) r[amb_pkg::CH_Z] = clip16(z);
		for (int k = 1; k <= ord; k++) begin
			ph = azp * 32'(k);
			slot = (k == 1) ? int'(amb_pkg::CH_X) :
				(k == 2) ? int'(amb_pkg::CH_U) : int'(amb_pkg::CH_P);
			r[slot] = harmonic(s, cos_q15(ph), ce, k, use_el);
			r[slot + 1] = harmonic(s, sin_q15(ph), ce, k, use_el);
		end
		m_prev_az = az;
		m_prev_el = el;
		return r;
	endfunction

	task automatic report(string msg);
		$display("%t mismatch: %s", $time, msg);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		chans_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {q_channel, p_channel, v_channel, u_channel,
				z_channel, y_channel, x_channel, w_channel};
			n_results++;
			if (encoded_q.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				want = encoded_q.pop_front();
				for (int c = 0; c < 8; c++)
					if (got[c] !== want[c])
						report($sformatf("result %0d ch %s got %0d want %0d", n_results,
							ch_name[c], $signed(got[c]), $signed(want[c])));
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		if (($urandom_range(0, 299)) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 9) < 3);
			2: out_stall <= ($urandom_range(0, 9) < 8);
			default: out_stall <= out_stall ^ ($urandom_range(0, 15) == 0);
		endcase
	end

	task automatic send_sample(logic signed [15:0] s, logic [15:0] az, logic [15:0] el);
		in_valid <= 1'b1;
		audio_sample <= s;
		azimuth_turn <= az;
		elevation_frac <= el;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		encoded_q.push_back(encode(s, az, el));
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
				$urandom_range(0, 8);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (encoded_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			amb_pkg::REG_ORDER: m_order = val[1:0];
			amb_pkg::REG_AZ: m_fix_az = val;
			amb_pkg::REG_EL: m_fix_el = val;
			default: ;
		endcase
	endtask

	task automatic set_all(logic [1:0] ord, logic [15:0] az, logic [15:0] el);
		drain();
		write_reg(amb_pkg::REG_ORDER, 16'(ord));
		write_reg(amb_pkg::REG_AZ, az);
		write_reg(amb_pkg::REG_EL, el);
		cfg_valid <= 1'b0;
	endtask

	// register angles with zero register elevation right after reset, then per-sample angles
	task automatic test_reset_defaults();
		send_sample(16'sh7fff, 16'h0000, 16'h0000);
		send_sample(-16'sd32768, 16'h0000, 16'h0000);
		send_sample(16'sd1000, 16'hffff, 16'hffff);
	endtask

	task automatic test_orders();
		for (int o = 0; o < 4; o++) begin
			set_all(o[1:0], 16'h2000, 16'h0000);
			send_sample(-16'sd32768, 16'h4000, 16'h8000);
			send_sample(16'sh7fff, 16'h1555, 16'h8000);
			send_sample(16'sh7fff, 16'h1555, 16'h8000);
		end
	endtask

	task automatic test_register_angles();
		set_all(2'd3, 16'hffff, 16'hffff);
		send_sample(16'sd12345, 16'h1234, 16'h4321);
		send_sample(-16'sd32768, 16'h1234, 16'h4321);
		set_all(2'd1, 16'h0000, 16'h0001);
		send_sample(16'sh7fff, 16'h1234, 16'h4321);
		send_sample(16'sd0, 16'h1234, 16'h4321);
	endtask

	// azimuth moves while the elevation stays put
	task automatic test_elevation_held();
		set_all(2'd3, 16'h5000, 16'hc000);
		send_sample(16'sh7fff, 16'h0100, 16'h3000);
		send_sample(-16'sd32768, 16'h8000, 16'h3000);
		send_sample(16'sd777, 16'hffff, 16'h3000);
	endtask

	task automatic test_random(int count);
		logic [15:0] az, el;
		logic signed [15:0] s;
		int r;
		az = m_prev_az;
		el = m_prev_el;
		for (int i = 0; i < count; i++) begin
			if (i % 250 == 0) begin
				if (i == 750) drain();
				r = $urandom_range(0, 3);
				set_all(2'($urandom_range(0, 3)),
					(r == 0) ? 16'hffff : 16'($urandom),
					(r == 1) ? 16'h0000 : (r == 2) ? 16'hffff : 16'($urandom));
			end
			r = $urandom_range(0, 7);
			if (r >= 4) begin
			end else if (r >= 2) begin
				az = 16'($urandom);
			end else if (r == 1) begin
				el = 16'($urandom);
			end else begin
				az = 16'($urandom);
				el = 16'($urandom);
			end
			r = $urandom_range(0, 9);
			s = (r == 0) ? 16'sh7fff : (r == 1) ? -16'sd32768 : 16'($urandom);
			send_sample(s, az, el);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_orders();
		test_register_angles();
		test_elevation_held();
		test_random(2000);
		drain();
		repeat (100) @(posedge clk);
		$display("Encoded %0d samples and checked %0d results over orders 0-3,", n_sent,
			n_results);
		$display("per-sample and register angles, with random gaps and stalls.");
		if (errors == 0 && encoded_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire
